// ===== hw/rtl/tks_pkg.sv =====
package tks_pkg;

  localparam int unsigned IDX_W  = 31;
  localparam int unsigned DIST_W = 32;
  localparam int unsigned NC_W   = 7;

  localparam logic ACT_OFFER = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};
  localparam logic [NC_W-1:0] NC_RESET = 7'd64;

  typedef struct packed {
    logic                     action;
    logic [IDX_W-1:0]         point_index;
    logic signed [DIST_W-1:0] distance;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_index;
    logic signed [DIST_W-1:0] out_distance;
    logic                     entry_valid;
    logic                     last_entry;
  } result_t;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DIST_W-1:0] distance;
  } entry_t;

endpackage

// ===== hw/rtl/top_k_smallest_selection_unit.sv =====
// Keeps the k smallest-distance candidates offered for one query.
// Command channel: an item (cmd) transfers at a clock edge where start is high
// and busy is low. An offer (action 0) appends the candidate while fewer than k
// are kept; once full, a strictly smaller distance replaces the worst entry.
// A flush (action 1) reads the kept entries out in slot order and clears them.
// Results appear on result for one cycle each, marked by result_valid; the
// receiver cannot stall them. An empty flush gives one entry with entry_valid 0.
// A fill offer or a rejected offer leaves busy low.
// A replacement starts a rescan of the kept entries through the single store
// read port and the one signed comparator, with busy high until it ends.
// A flush keeps busy high while its entries are read through the store read
// register and then the result register; the last one shows in the first idle cycle.
// An empty flush answers in the next cycle.
// The k register (cfg_data) transfers on cfg_valid with cfg_ready, always high;
// write it only while idle. Zero acts as one, values above MAX_NEIGHBORS clamp.
// Reset empties the store and sets k to 64; the store needs no clearing pass.
module top_k_smallest_selection_unit #(
  parameter int unsigned MAX_NEIGHBORS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  tks_pkg::cmd_t                cmd,
  output logic                         result_valid,
  output tks_pkg::result_t             result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tks_pkg::NC_W-1:0]     cfg_data
);
  import tks_pkg::*;

  localparam int unsigned SLOT_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_NEIGHBORS + 1);
  localparam logic [NC_W-1:0] MAX_NC = NC_W'(MAX_NEIGHBORS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]               state;
  logic [NC_W-1:0]          nc;
  logic [CNT_W-1:0]         kept;
  logic signed [DIST_W-1:0] worst_dist;
  logic [SLOT_W-1:0]        worst_slot;
  logic signed [DIST_W-1:0] best;
  logic [SLOT_W-1:0]        best_slot;
  logic [SLOT_W-1:0]        cnt;
  logic                     issuing;
  logic                     rd_vld;
  logic [SLOT_W-1:0]        rd_slot;
  logic                     rd_last;

  logic [NC_W-1:0]          eff_k;
  logic                     accept;
  logic                     fill;
  logic                     replace;
  logic                     issue_last;
  logic                     wr_en;
  logic [SLOT_W-1:0]        wr_addr;
  entry_t                   wr_data;
  entry_t                   rd_data;
  logic                     gt;
  logic signed [DIST_W-1:0] best_next;
  logic [SLOT_W-1:0]        best_slot_next;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_comb begin
    if (nc == '0) begin
      eff_k = NC_W'(1);
    end else if (nc > MAX_NC) begin
      eff_k = MAX_NC;
    end else begin
      eff_k = nc;
    end
  end

  assign fill    = (NC_W'(kept) < eff_k);
  assign replace = !fill && (cmd.distance < worst_dist);

  assign wr_en            = accept && (cmd.action == ACT_OFFER) && (fill || replace);
  assign wr_addr          = fill ? kept[SLOT_W-1:0] : worst_slot;
  assign wr_data.idx      = cmd.point_index;
  assign wr_data.distance = cmd.distance;

  assign issue_last = (CNT_W'(cnt) == kept - CNT_W'(1));

  // The one comparator shared by every step of the rescan.
  assign gt             = (rd_data.distance > best);
  assign best_next      = gt ? rd_data.distance : best;
  assign best_slot_next = gt ? rd_slot : best_slot;

  tks_store #(
    .DEPTH (MAX_NEIGHBORS),
    .AW    (SLOT_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issuing),
    .rd_addr (cnt),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      nc           <= NC_RESET;
      kept         <= '0;
      worst_dist   <= DIST_MIN;
      worst_slot   <= '0;
      issuing      <= 1'b0;
      rd_vld       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= ((state == ST_IDLE) && accept && (cmd.action == ACT_FLUSH) &&
                       (kept == '0)) || ((state == ST_FLUSH) && rd_vld);
      if (cfg_valid && cfg_ready) begin
        nc <= cfg_data;
      end

      // Read issue: one slot per cycle; the store registers the data, which shows in the next cycle.
      rd_vld <= issuing;
      if (issuing) begin
        rd_slot <= cnt;
        rd_last <= issue_last;
        if (issue_last) begin
          issuing <= 1'b0;
        end else begin
          cnt <= cnt + SLOT_W'(1);
        end
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (cmd.action == ACT_OFFER) begin
              if (fill) begin
                if (cmd.distance > worst_dist) begin
                  worst_dist <= cmd.distance;
                  worst_slot <= kept[SLOT_W-1:0];
                end
                kept <= kept + CNT_W'(1);
              end else if (replace) begin
                state     <= ST_SCAN;
                cnt       <= '0;
                issuing   <= 1'b1;
                best      <= DIST_MIN;
                best_slot <= '0;
              end
            end else if (kept == '0) begin
              result.out_index    <= '0;
              result.out_distance <= '0;
              result.entry_valid  <= 1'b0;
              result.last_entry   <= 1'b1;
              worst_dist          <= DIST_MIN;
              worst_slot          <= '0;
            end else begin
              state   <= ST_FLUSH;
              cnt     <= '0;
              issuing <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (rd_vld) begin
            best      <= best_next;
            best_slot <= best_slot_next;
            if (rd_last) begin
              worst_dist <= best_next;
              worst_slot <= best_slot_next;
              state      <= ST_IDLE;
            end
          end
        end
        ST_FLUSH: begin
          if (rd_vld) begin
            result.out_index    <= rd_data.idx;
            result.out_distance <= rd_data.distance;
            result.entry_valid  <= 1'b1;
            result.last_entry   <= rd_last;
            if (rd_last) begin
              kept       <= '0;
              worst_dist <= DIST_MIN;
              worst_slot <= '0;
              state      <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // The store never holds more entries than it has slots.
  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(kept) <= CNT_W'(MAX_NEIGHBORS))
    else $error("kept count exceeds store depth");

  // The final entry of a flush coincides with the return to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_entry |-> !busy)
    else $error("flush ended but block still busy");

  // Entries before the last one come out only while the flush is running.
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_entry |-> busy)
    else $error("flush entry emitted outside a flush");

  // No read is in flight while the block is idle.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !rd_vld && !issuing)
    else $error("store read active while idle");

  // The store is already empty while the last entry of a flush is shown.
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_entry |-> kept == '0)
    else $error("flush did not clear the store");
`endif

endmodule

// ===== hw/rtl/tks_store.sv =====
module tks_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  tks_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output tks_pkg::entry_t rd_data
);
  import tks_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import tks_pkg::*;

  localparam int unsigned MAX_NEIGHBORS = 64;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam logic signed [DIST_W-1:0] DIST_MAX = ~DIST_MIN;

  // Tracks the kept neighbors the same way the block should and queues the
  // entries each flush is expected to stream out.
  class top_k_scoreboard;
    logic [IDX_W-1:0]         slot_idx [MAX_NEIGHBORS];
    logic signed [DIST_W-1:0] slot_dist [MAX_NEIGHBORS];
    int unsigned              kept;
    int unsigned              worst_pos;
    logic signed [DIST_W-1:0] worst_dist;
    logic [NC_W-1:0]          k_reg;
    result_t                  expected_q [$];
    int unsigned              errors;
    int unsigned              checked;
    int unsigned              commands;
    int unsigned              flushes;
    int unsigned              k_writes;

    function new();
      kept = 0;
      worst_pos = 0;
      worst_dist = DIST_MIN;
      k_reg = NC_RESET;
      errors = 0;
      checked = 0;
      commands = 0;
      flushes = 0;
      k_writes = 0;
    endfunction

    static function int unsigned clamp_k(logic [NC_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_NEIGHBORS) return MAX_NEIGHBORS;
      return 32'(v);
    endfunction

    function void set_k(logic [NC_W-1:0] v);
      k_reg = v;
      k_writes++;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_command(cmd_t c);
      logic signed [DIST_W-1:0] d;
      result_t r;
      d = c.distance;
      commands++;
      if (c.action == ACT_OFFER) begin
        if (kept < clamp_k(k_reg)) begin
          if (d > worst_dist) begin
            worst_dist = d;
            worst_pos = kept;
          end
          slot_idx[kept] = c.point_index;
          slot_dist[kept] = d;
          kept++;
        end else if (d < worst_dist) begin
          slot_idx[worst_pos] = c.point_index;
          slot_dist[worst_pos] = d;
          // Rescan for the new worst entry; the lowest slot wins ties.
          worst_dist = DIST_MIN;
          worst_pos = 0;
          for (int unsigned s = 0; s < kept; s++) begin
            if (slot_dist[s] > worst_dist) begin
              worst_dist = slot_dist[s];
              worst_pos = s;
            end
          end
        end
      end else begin
        flushes++;
        if (kept == 0) begin
          r.out_index = '0;
          r.out_distance = '0;
          r.entry_valid = 1'b0;
          r.last_entry = 1'b1;
          expected_q = {expected_q, r};
        end else begin
          for (int unsigned s = 0; s < kept; s++) begin
            r.out_index = slot_idx[s];
            r.out_distance = slot_dist[s];
            r.entry_valid = 1'b1;
            r.last_entry = (s + 1 == kept);
            expected_q = {expected_q, r};
          end
        end
        kept = 0;
        worst_dist = DIST_MIN;
        worst_pos = 0;
      end
    endfunction

    function void check_result(result_t r);
      result_t e;
      checked++;
      if (expected_q.size() == 0) begin
        $error("unexpected result: out_index %0d out_distance %0d entry_valid %0b last_entry %0b",
               r.out_index, r.out_distance, r.entry_valid, r.last_entry);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (r.out_index !== e.out_index) begin
        $error("out_index: expected %0d, actual %0d", e.out_index, r.out_index);
        errors++;
      end
      if (r.out_distance !== e.out_distance) begin
        $error("out_distance: expected %0d, actual %0d", e.out_distance, r.out_distance);
        errors++;
      end
      if (r.entry_valid !== e.entry_valid) begin
        $error("entry_valid: expected %0b, actual %0b", e.entry_valid, r.entry_valid);
        errors++;
      end
      if (r.last_entry !== e.last_entry) begin
        $error("last_entry: expected %0b, actual %0b", e.last_entry, r.last_entry);
        errors++;
      end
    endfunction
  endclass

  logic            clk;
  logic            rst;
  logic            start;
  logic            busy;
  cmd_t            cmd;
  logic            result_valid;
  result_t         result;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [NC_W-1:0] cfg_data;

  top_k_scoreboard sb;
  logic            start_held;
  logic            steady;
  int unsigned     burst_left;
  int unsigned     idle_cycles;

  top_k_smallest_selection_unit #(
    .MAX_NEIGHBORS(MAX_NEIGHBORS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .result_valid(result_valid),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      sb.check_result(result);
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic issue(input logic act, input logic [IDX_W-1:0] idx,
                       input logic signed [DIST_W-1:0] dist_code);
    cmd_t c;
    c.action = act;
    c.point_index = idx;
    c.distance = dist_code;
    start <= 1'b1;
    start_held = 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    sb.note_command(c);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      if (!steady) begin
        start <= 1'b0;
        start_held = 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  task automatic offer(input logic [IDX_W-1:0] idx,
                       input logic signed [DIST_W-1:0] dist_code);
    issue(ACT_OFFER, idx, dist_code);
  endtask

  task automatic flush();
    issue(ACT_FLUSH, IDX_W'($urandom()), $signed($urandom()));
  endtask

  // An offer gives no result, so a replacement rescan may still be running
  // when the queue drains; the pause covers the longest one.
  task automatic wait_idle();
    if (start_held) begin
      start <= 1'b0;
      start_held = 1'b0;
    end
    while (sb.pending() != 0) @(posedge clk);
    repeat (MAX_NEIGHBORS + 8) @(posedge clk);
  endtask

  task automatic write_k(input logic [NC_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_k(v);
  endtask

  function automatic logic signed [DIST_W-1:0] pick_distance();
    case ($urandom_range(0, 9))
      0: return DIST_MIN;
      1: return DIST_MAX;
      2, 3, 4: return $urandom();
      default: return $signed($urandom_range(0, 40)) - 20;
    endcase
  endfunction

  function automatic logic [NC_W-1:0] pick_k(int unsigned phase);
    if (phase == 0) return 7'd127;
    if (phase == 1) return 7'd1;
    if (phase == 2) return 7'd64;
    case ($urandom_range(0, 7))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd64;
      3: return 7'd127;
      4: return NC_W'($urandom_range(65, 127));
      5: return NC_W'($urandom_range(0, 127));
      default: return NC_W'($urandom_range(2, 12));
    endcase
  endfunction

  initial begin
    int unsigned     phase;
    int unsigned     directed;
    int unsigned     queries;
    int unsigned     n;
    logic [NC_W-1:0] k;

    sb = new();
    rst = 1'b1;
    start = 1'b0;
    start_held = 1'b0;
    cmd = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    steady = 1'b0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset value of k, field extremes, and a flush with nothing kept.
    flush();
    offer('0, DIST_MIN);
    offer({IDX_W{1'b1}}, DIST_MAX);
    offer(1, -1);
    offer(2, 0);
    flush();

    // All kept distances at the most negative code: worst slot stays at zero
    // and an equal distance is not taken.
    wait_idle();
    write_k(3);
    offer(10, DIST_MIN);
    offer(11, DIST_MIN);
    offer(12, DIST_MIN);
    offer(13, DIST_MIN);
    flush();

    // Replacement of the worst slot, including an equal distance that loses.
    offer(20, 10);
    offer(21, 30);
    offer(22, 20);
    offer(23, 30);
    offer(24, 5);
    offer(25, -7);
    flush();

    // Equal distance in fill, then k lowered below the number kept.
    wait_idle();
    write_k(4);
    offer(30, 40);
    offer(31, 10);
    offer(32, 40);
    offer(33, 0);
    wait_idle();
    write_k(2);
    offer(34, -50);
    flush();

    // A k of zero behaves as one.
    wait_idle();
    write_k(0);
    offer(40, 8);
    offer(41, 3);
    flush();
    directed = sb.commands;

    phase = 0;
    while (sb.commands < directed + RANDOM_ITEMS) begin
      wait_idle();
      k = pick_k(phase);
      write_k(k);
      steady = ($urandom_range(0, 3) == 0);
      queries = $urandom_range(1, 4);
      for (int unsigned q = 0; q < queries; q++) begin
        n = top_k_scoreboard::clamp_k(k);
        n = $urandom_range(0, n + n / 2 + 4);
        for (int unsigned i = 0; i < n; i++) begin
          offer(IDX_W'($urandom()), pick_distance());
        end
        // Sometimes the store is left filled so that the next k applies to it.
        if (q + 1 < queries || $urandom_range(0, 3) != 0) begin
          flush();
          if ($urandom_range(0, 7) == 0) begin
            flush();
          end
        end
      end
      phase++;
    end

    wait_idle();
    $display("%0d commands (%0d flushes), %0d k settings over %0d phases",
             sb.commands, sb.flushes, sb.k_writes, phase);
    $display("%0d result entries checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
